// ----- hw/rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  // Register stages from input to output
  localparam int unsigned STAGES = 7;

  // One full turn of hue and one 60-degree sector, in 1/16 degree
  localparam logic [15:0] HUE_TURN    = 16'd5760;
  localparam logic [12:0] HUE_SECTOR  = 13'd960;
  localparam logic [9:0]  SECTOR_SPAN = 10'd960;

  // Rounding offset for X: half of 255*960
  localparam logic [25:0] X_ROUND = 26'd122400;

  // X = floor(n / 3825) with n = (P*w + X_ROUND) >> 6, via a reciprocal
  // estimate (2^20 / 3825, rounded down) and one upward correction
  localparam logic [8:0]  RECIP_K   = 9'd274;
  localparam logic [11:0] DIV_LOW   = 12'd3825;

  // Hue sectors, 60 degrees each
  localparam logic [2:0] SEC_RED_YEL   = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
  localparam logic [2:0] SEC_GRN_CYAN  = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG   = 3'd4;
  localparam logic [2:0] SEC_MAG_RED   = 3'd5;

  typedef logic [STAGES-1:0] stage_vec_t;

endpackage

// ----- hw/rtl/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter. Each request carries one pixel: a signed hue in
// 1/16 degree (negative hues are mirrored, so -30 degrees acts as +30), and
// 8-bit saturation and value where 255 means 1.0. The result is one 8-bit
// R, G, B triple, rounded to nearest. The block holds no state between pixels
// and takes one pixel every clock unless a stall on the output has filled
// every stage. A pixel passes through the seven register stages of the
// datapath in order (hue magnitude and V*S, fold and chroma, sector,
// multiply, reciprocal estimate, correction, mix) to the output register.
// Ready ripples back through the stages, so an empty stage is refilled even
// while the output is held, and up to 7 pixels can be in flight.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] hue, [23:16] saturation, [31:24] brightness
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);
  import hsv2rgb_pkg::*;

  stage_vec_t         load;
  logic signed [15:0] hue;
  logic [7:0]         saturation;
  logic [7:0]         brightness;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;

  // Unpack the request fields
  assign hue        = $signed(in_tdata[15:0]);
  assign saturation = in_tdata[23:16];
  assign brightness = in_tdata[31:24];

  // Advance each stage when it is empty or its successor takes its pixel
  hsv2rgb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .load       (load)
  );

  // Hold payload in stage registers; no reset needed on them
  hsv2rgb_datapath u_datapath (
    .clk        (clk),
    .load       (load),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out)
  );

  // Pack the result fields
  assign out_tdata = {blue_out, green_out, red_out};

endmodule

// ----- hw/rtl/hsv2rgb_ctrl.sv -----
module hsv2rgb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output hsv2rgb_pkg::stage_vec_t load
);
  import hsv2rgb_pkg::*;

  stage_vec_t vld_r;
  stage_vec_t vld_nxt;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    load[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (load[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = load[0];
  assign out_tvalid = vld_r[STAGES-1];

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input held off while a stage is empty");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted request did not enter first stage");

  a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STAGES-2] && !load[STAGES-1]) |=> vld_r[STAGES-2])
    else $error("stalled request dropped before last stage");

endmodule

// ----- hw/rtl/hsv2rgb_datapath.sv -----
module hsv2rgb_datapath (
  input  logic                    clk,
  input  hsv2rgb_pkg::stage_vec_t load,
  input  logic signed [15:0]      hue,
  input  logic [7:0]              saturation,
  input  logic [7:0]              brightness,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out
);
  import hsv2rgb_pkg::*;

  // stage 0: hue magnitude, P = V*S
  logic [15:0] mag0_r, mag0_nxt;
  logic [15:0] p0_r, p0_nxt;
  logic [7:0]  v0_r;

  // stage 1: hue modulo one turn, chroma
  logic [12:0] fold1_r, fold1_nxt;
  logic [15:0] p1_r;
  logic [7:0]  v1_r, c1_r, c1_nxt;

  // stage 2: sector and triangular weight
  logic [2:0]  sec2_r, sec2_nxt;
  logic [9:0]  w2_r, w2_nxt;
  logic [15:0] p2_r;
  logic [7:0]  v2_r, c2_r;

  // stage 3: rounded P*w
  logic [25:0] pw3_r, pw3_nxt;
  logic [2:0]  sec3_r;
  logic [7:0]  v3_r, c3_r;

  // stage 4: reciprocal estimate
  logic [28:0] est4_r, est4_nxt;
  logic [19:0] n4_r;
  logic [2:0]  sec4_r;
  logic [7:0]  v4_r, c4_r;

  // stage 5: corrected X and offset m
  logic [7:0]  x5_r, x5_nxt;
  logic [7:0]  m5_r, m5_nxt;
  logic [7:0]  c5_r;
  logic [2:0]  sec5_r;

  // stage 6: output
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;

  logic [2:0]  turns;
  logic [15:0] fold_full;
  logic [16:0] c_bias;
  logic [17:0] c_sum;
  logic [12:0] f_full;
  logic [9:0]  f_pos;
  logic [7:0]  q_est;
  logic [19:0] q_thr;

  always_comb begin
    mag0_nxt = hue[15] ? (~$unsigned(hue) + 16'd1) : $unsigned(hue);
    p0_nxt   = {8'b0, brightness} * {8'b0, saturation};
  end

  // mirror-folded hue reduced by whole turns; chroma = round(P/255)
  always_comb begin
    turns = 3'd0;
    for (int n = 1; n <= 5; n++) begin
      if (mag0_r >= 16'(n) * HUE_TURN) begin
        turns = 3'(n);
      end
    end
    fold_full = mag0_r - {13'b0, turns} * HUE_TURN;
    fold1_nxt = fold_full[12:0];
    c_bias    = {1'b0, p0_r} + 17'd127;
    c_sum     = {1'b0, c_bias} + {9'b0, c_bias[16:8]} + 18'd1;
    c1_nxt    = c_sum[15:8];
  end

  always_comb begin
    sec2_nxt = SEC_RED_YEL;
    for (int n = 1; n <= 5; n++) begin
      if (fold1_r >= 13'(n) * HUE_SECTOR) begin
        sec2_nxt = 3'(n);
      end
    end
    f_full = fold1_r - {10'b0, sec2_nxt} * HUE_SECTOR;
    f_pos  = f_full[9:0];
    w2_nxt = sec2_nxt[0] ? (SECTOR_SPAN - f_pos) : f_pos;
  end

  always_comb begin
    pw3_nxt  = ({10'b0, p2_r} * {16'b0, w2_r}) + X_ROUND;
    est4_nxt = {9'b0, pw3_r[25:6]} * {20'b0, RECIP_K};
  end

  // estimate is exact or one low; bump it when the next multiple still fits
  always_comb begin
    q_est  = est4_r[27:20];
    q_thr  = ({12'b0, q_est} + 20'd1) * {8'b0, DIV_LOW};
    x5_nxt = (n4_r >= q_thr) ? (q_est + 8'd1) : q_est;
    m5_nxt = v4_r - c4_r;
  end

  always_comb begin
    case (sec5_r)
      SEC_RED_YEL: begin
        red_nxt = c5_r + m5_r; green_nxt = x5_r + m5_r; blue_nxt = m5_r;
      end
      SEC_YEL_GRN: begin
        red_nxt = x5_r + m5_r; green_nxt = c5_r + m5_r; blue_nxt = m5_r;
      end
      SEC_GRN_CYAN: begin
        red_nxt = m5_r; green_nxt = c5_r + m5_r; blue_nxt = x5_r + m5_r;
      end
      SEC_CYAN_BLU: begin
        red_nxt = m5_r; green_nxt = x5_r + m5_r; blue_nxt = c5_r + m5_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = x5_r + m5_r; green_nxt = m5_r; blue_nxt = c5_r + m5_r;
      end
      default: begin
        red_nxt = c5_r + m5_r; green_nxt = m5_r; blue_nxt = x5_r + m5_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      mag0_r <= mag0_nxt;
      p0_r   <= p0_nxt;
      v0_r   <= brightness;
    end
    if (load[1]) begin
      fold1_r <= fold1_nxt;
      c1_r    <= c1_nxt;
      p1_r    <= p0_r;
      v1_r    <= v0_r;
    end
    if (load[2]) begin
      sec2_r <= sec2_nxt;
      w2_r   <= w2_nxt;
      p2_r   <= p1_r;
      v2_r   <= v1_r;
      c2_r   <= c1_r;
    end
    if (load[3]) begin
      pw3_r  <= pw3_nxt;
      sec3_r <= sec2_r;
      v3_r   <= v2_r;
      c3_r   <= c2_r;
    end
    if (load[4]) begin
      est4_r <= est4_nxt;
      n4_r   <= pw3_r[25:6];
      sec4_r <= sec3_r;
      v4_r   <= v3_r;
      c4_r   <= c3_r;
    end
    if (load[5]) begin
      x5_r   <= x5_nxt;
      m5_r   <= m5_nxt;
      c5_r   <= c4_r;
      sec5_r <= sec4_r;
    end
    if (load[6]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red_out   = red_r;
  assign green_out = green_r;
  assign blue_out  = blue_r;

endmodule
